// ===== src/pl0ts_pkg.sv =====
package pl0ts_pkg;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_NUMBER, M_LESS, M_GREATER, M_COLON, M_SLASH,
		M_COMMENT, M_STAR, M_HALT
	} mode_t;

	localparam logic [2:0] ST_TOKEN   = 3'd0;
	localparam logic [2:0] ST_STRAY   = 3'd1;
	localparam logic [2:0] ST_COLON   = 3'd2;
	localparam logic [2:0] ST_BADID   = 3'd3;
	localparam logic [2:0] ST_NUMLONG = 3'd4;
	localparam logic [2:0] ST_UNTERM  = 3'd5;
	localparam logic [2:0] ST_DONE    = 3'd6;

	localparam logic [4:0] K_IDENT = 5'd0, K_NUMBER = 5'd1, K_PLUS = 5'd2, K_MINUS = 5'd3,
		K_MULT = 5'd4, K_SLASH = 5'd5, K_EQ = 5'd6, K_NEQ = 5'd7, K_LES = 5'd8,
		K_LEQ = 5'd9, K_GTR = 5'd10, K_GEQ = 5'd11, K_BECOMES = 5'd12,
		K_LPAREN = 5'd13, K_RPAREN = 5'd14, K_COMMA = 5'd15, K_SEMI = 5'd16,
		K_PERIOD = 5'd17, K_CONST = 5'd18, K_INT = 5'd19, K_PROC = 5'd20,
		K_CALL = 5'd21, K_BEGIN = 5'd22, K_END = 5'd23, K_IF = 5'd24,
		K_THEN = 5'd25, K_ELSE = 5'd26, K_WHILE = 5'd27, K_DO = 5'd28,
		K_IN = 5'd29, K_OUT = 5'd30, K_ODD = 5'd31;

	localparam int KEEP = 9;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  kind;
		logic [15:0] line;
		logic [15:0] col;
		logic [7:0]  len;
		logic        last;
	} res_t;

	// front to back: up to two results per beat
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} pair_t;

endpackage

// ===== src/pl0ts_front.sv =====
module pl0ts_front import pl0ts_pkg::*; #(
	parameter int IDENT_LIMIT  = 12,
	parameter int NUMBER_LIMIT = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        alias_rw,
	input  logic        take,
	input  logic [7:0]  ch,
	input  logic        end_of_input,
	input  logic [15:0] char_line,
	input  logic [15:0] char_col,
	output logic        pv,
	output pair_t       pd
);

	mode_t       mode_q, mode_d;
	logic [7:0]  lx_q [KEEP];
	logic [7:0]  len_q, len_d;
	logic [15:0] sl_q, sc_q, sl_d, sc_d;
	logic        wr_en;

	function automatic res_t mk(logic [2:0] s, logic [4:0] k, logic [15:0] l,
		logic [15:0] c, logic [7:0] n);
		res_t r;
		r.status = s; r.kind = k; r.line = l; r.col = c; r.len = n; r.last = 1'b0;
		return r;
	endfunction

	function automatic logic [7:0] cc(string s, int i);
		return s.getc(i);
	endfunction

	logic is_a, is_d;
	assign is_a = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
	assign is_d = ch >= "0" && ch <= "9";

	function automatic logic wm(logic [7:0] lx [KEEP], logic [7:0] n, string w);
		logic ok;
		ok = (n == 8'(w.len()));
		for (int i = 0; i < KEEP; i++)
			if (i < w.len() && lx[i] != cc(w, i)) ok = 1'b0;
		return ok;
	endfunction

	logic [4:0] wkind;
	always_comb begin
		wkind = K_IDENT;
		priority if (wm(lx_q, len_q, "const")) wkind = K_CONST;
		else if (wm(lx_q, len_q, "int")) wkind = K_INT;
		else if (wm(lx_q, len_q, "procedure")) wkind = K_PROC;
		else if (wm(lx_q, len_q, "call")) wkind = K_CALL;
		else if (wm(lx_q, len_q, "begin")) wkind = K_BEGIN;
		else if (wm(lx_q, len_q, "end")) wkind = K_END;
		else if (wm(lx_q, len_q, "if")) wkind = K_IF;
		else if (wm(lx_q, len_q, "then")) wkind = K_THEN;
		else if (wm(lx_q, len_q, "else")) wkind = K_ELSE;
		else if (wm(lx_q, len_q, "while")) wkind = K_WHILE;
		else if (wm(lx_q, len_q, "do")) wkind = K_DO;
		else if (wm(lx_q, len_q, "in")) wkind = K_IN;
		else if (wm(lx_q, len_q, "out")) wkind = K_OUT;
		else if (wm(lx_q, len_q, "odd")) wkind = K_ODD;
		else if (alias_rw && wm(lx_q, len_q, "read")) wkind = K_IN;
		else if (alias_rw && wm(lx_q, len_q, "write")) wkind = K_OUT;
		else wkind = K_IDENT;
	end

	always_comb begin
		res_t  q [2];
		logic [1:0] n;
		logic  fin_ok, do_begin;
		logic  single;
		logic [4:0] sk;
		mode_d = mode_q; len_d = len_q; sl_d = sl_q; sc_d = sc_q; wr_en = 1'b0;
		q[0] = '0; q[1] = '0; n = '0;
		fin_ok = 1'b1; do_begin = 1'b0; single = 1'b0; sk = K_PLUS;
		if (mode_q != M_HALT) begin
			if (end_of_input) begin
				unique case (mode_q)
					M_COLON: begin
						q[0] = mk(ST_COLON, K_IDENT, sl_q, sc_q, 8'd1); n = 2'd1;
						mode_d = M_HALT; fin_ok = 1'b0;
					end
					M_COMMENT, M_STAR: begin
						q[0] = mk(ST_UNTERM, K_IDENT, sl_q, sc_q, 8'd0); n = 2'd1;
					end
					default: ;
				endcase
			end
			// finish pending token
			if (end_of_input || mode_q == M_IDENT && !(is_a || is_d)
				|| mode_q == M_NUMBER && !is_d && !is_a
				|| mode_q == M_LESS && ch != "=" && ch != ">"
				|| mode_q == M_GREATER && ch != "=" || mode_q == M_SLASH && ch != "*"
				|| mode_q == M_IDLE) begin
				do_begin = !end_of_input;
				unique case (mode_q)
					M_IDENT: if (len_q >= 8'(IDENT_LIMIT)) begin
						q[0] = mk(ST_BADID, K_IDENT, sl_q, sc_q, len_q); n = 2'd1;
						mode_d = M_HALT; fin_ok = 1'b0;
					end else begin
						q[0] = mk(ST_TOKEN, wkind, sl_q, sc_q, len_q); n = 2'd1;
					end
					M_NUMBER: if (len_q >= 8'(NUMBER_LIMIT)) begin
						q[0] = mk(ST_NUMLONG, K_IDENT, sl_q, sc_q, len_q); n = 2'd1;
						mode_d = M_HALT; fin_ok = 1'b0;
					end else begin
						q[0] = mk(ST_TOKEN, K_NUMBER, sl_q, sc_q, len_q); n = 2'd1;
					end
					M_LESS: begin q[0] = mk(ST_TOKEN, K_LES, sl_q, sc_q, 8'd1); n = 2'd1; end
					M_GREATER: begin q[0] = mk(ST_TOKEN, K_GTR, sl_q, sc_q, 8'd1); n = 2'd1; end
					M_SLASH: begin q[0] = mk(ST_TOKEN, K_SLASH, sl_q, sc_q, 8'd1); n = 2'd1; end
					default: ;
				endcase
				if (fin_ok) mode_d = M_IDLE;
			end
			if (end_of_input) begin
				if (mode_d != M_HALT) begin
					q[n[0]] = mk(ST_DONE, K_IDENT, char_line, char_col, 8'd0);
					n = n + 2'd1; mode_d = M_IDLE;
				end
			end else if (do_begin && fin_ok) begin
				mode_d = M_IDLE;
				unique case (ch)
					"+": begin single = 1'b1; sk = K_PLUS; end
					"-": begin single = 1'b1; sk = K_MINUS; end
					"*": begin single = 1'b1; sk = K_MULT; end
					"(": begin single = 1'b1; sk = K_LPAREN; end
					")": begin single = 1'b1; sk = K_RPAREN; end
					"=": begin single = 1'b1; sk = K_EQ; end
					",": begin single = 1'b1; sk = K_COMMA; end
					".": begin single = 1'b1; sk = K_PERIOD; end
					";": begin single = 1'b1; sk = K_SEMI; end
					default: ;
				endcase
				if (ch == " " || ch == 8'h09 || ch == 8'h0a || ch == 8'h0d) begin
				end else if (single) begin
					q[n[0]] = mk(ST_TOKEN, sk, char_line, char_col, 8'd1); n = n + 2'd1;
				end else begin
					sl_d = char_line; sc_d = char_col; len_d = '0;
					priority if (ch == "<") mode_d = M_LESS;
					else if (ch == ">") mode_d = M_GREATER;
					else if (ch == ":") mode_d = M_COLON;
					else if (ch == "/") mode_d = M_SLASH;
					else if (is_a || is_d) begin
						mode_d = is_a ? M_IDENT : M_NUMBER; len_d = 8'd1; wr_en = 1'b1;
					end else begin
						q[n[0]] = mk(ST_STRAY, K_IDENT, char_line, char_col, 8'd1);
						n = n + 2'd1; mode_d = M_HALT;
					end
				end
			end else if (!end_of_input) begin
				unique case (mode_q)
					M_IDENT, M_NUMBER: begin
						if (mode_q == M_NUMBER && is_a) begin
							q[0] = mk(ST_BADID, K_IDENT, sl_q, sc_q, len_q); n = 2'd1;
							mode_d = M_HALT;
						end else if (mode_q == M_IDENT || is_d) begin
							wr_en = 1'b1;
							if (len_q != 8'd255) len_d = len_q + 8'd1;
						end
					end
					M_LESS: begin
						q[0] = mk(ST_TOKEN, ch == "=" ? K_LEQ : K_NEQ, sl_q, sc_q, 8'd2);
						n = 2'd1; mode_d = M_IDLE;
					end
					M_GREATER: begin
						q[0] = mk(ST_TOKEN, K_GEQ, sl_q, sc_q, 8'd2); n = 2'd1; mode_d = M_IDLE;
					end
					M_COLON: if (ch == "=") begin
						q[0] = mk(ST_TOKEN, K_BECOMES, sl_q, sc_q, 8'd2); n = 2'd1;
						mode_d = M_IDLE;
					end else begin
						q[0] = mk(ST_COLON, K_IDENT, sl_q, sc_q, 8'd1); n = 2'd1;
						mode_d = M_HALT;
					end
					M_SLASH: mode_d = M_COMMENT;
					M_COMMENT: if (ch == "*") mode_d = M_STAR;
					M_STAR: if (ch == "/") mode_d = M_IDLE;
						else if (ch != "*") mode_d = M_COMMENT;
					default: ;
				endcase
			end
		end
		if (n == 2'd1) q[0].last = 1'b1;
		if (n == 2'd2) q[1].last = 1'b1;
		pd.n = n; pd.r0 = q[0]; pd.r1 = q[1];
	end

	assign pv = take && pd.n != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			len_q  <= '0;
			sl_q   <= '0;
			sc_q   <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			len_q  <= len_d;
			sl_q   <= sl_d;
			sc_q   <= sc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take && wr_en && len_d != 8'd0 && len_d <= 8'(KEEP))
			lx_q[4'(len_d - 8'd1)] <= ch;
	end

endmodule

// ===== src/pl0ts_back.sv =====
module pl0ts_back import pl0ts_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  pv,
	input  pair_t pd,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output res_t  head
);

	// four-entry result queue; front needs room for two results per beat
	res_t       mem_q [4];
	logic [1:0] rp_q, wp_q;
	logic [2:0] cnt_q;
	logic       deq;

	assign empty = cnt_q == 3'd0;
	assign full  = cnt_q > 3'd2;
	assign head  = mem_q[rp_q];
	assign deq   = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0; wp_q <= '0; cnt_q <= '0;
		end else begin
			if (deq) rp_q <= rp_q + 2'd1;
			if (pv) wp_q <= wp_q + pd.n;
			cnt_q <= cnt_q + (pv ? {1'b0, pd.n} : 3'd0) - {2'b0, deq};
		end
	end

	always_ff @(posedge clk) begin
		if (pv) begin
			mem_q[wp_q] <= pd.r0;
			if (pd.n == 2'd2) mem_q[wp_q + 2'd1] <= pd.r1;
		end
	end

endmodule

// ===== src/pl0_token_scanner_unit.sv =====
// channel   direction  handshake       beat
// input     in         push / full     ch, end_of_input, char_line, char_col
// result    out        pop / empty     status, kind, tok_line, tok_col, tok_length, last
// config    in         cfg_we          cfg_data (alias_read_write)
// One input beat per cycle while full is low; the scanner classifies it in the cycle it is taken.
// Results wait in a four-entry queue; full rises when fewer than two slots remain.
// Reset clears scanner state, the queue and the alias flag.
// After an error other than an unterminated comment the block takes beats and drops them until reset.
module pl0_token_scanner_unit import pl0ts_pkg::*; #(
	parameter int IDENT_LIMIT  = 12,
	parameter int NUMBER_LIMIT = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  ch,
	input  logic        end_of_input,
	input  logic [15:0] char_line,
	input  logic [15:0] char_col,
	input  logic        pop,
	output logic        empty,
	output logic [2:0]  status,
	output logic [4:0]  kind,
	output logic [15:0] tok_line,
	output logic [15:0] tok_col,
	output logic [7:0]  tok_length,
	output logic        last
);

	logic  alias_q, pv;
	pair_t pd;
	res_t  head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) alias_q <= 1'b0;
		else if (cfg_we) alias_q <= cfg_data;
	end

	pl0ts_front #(.IDENT_LIMIT(IDENT_LIMIT), .NUMBER_LIMIT(NUMBER_LIMIT)) u_front (
		.clk, .arst_n, .alias_rw(alias_q), .take(push && !full), .ch, .end_of_input,
		.char_line, .char_col, .pv, .pd
	);

	pl0ts_back u_back (.clk, .arst_n, .pv, .pd, .full, .pop, .empty, .head);

	assign status = head.status;
	assign kind = head.kind;
	assign tok_line = head.line;
	assign tok_col = head.col;
	assign tok_length = head.len;
	assign last = head.last;

endmodule
